/* src/mavs_pkg.sv */
// Shared types, widths and constants for the per-channel median filter
// and voltage scaler. No dependencies; every other file uses it.
package mavs_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int WINDOW_DEF       = 5;

    localparam int DATA_W     = 10;
    localparam int REF_W      = 13;
    localparam int GAIN_W     = 15;
    localparam int VOLT_W     = 15;
    localparam int CHAN_W     = 3;
    localparam int NUM_GAINS  = 8;
    localparam int GIDX_W     = 3;
    localparam int PART_W     = DATA_W + REF_W;
    localparam int PROD_W     = PART_W + GAIN_W;
    localparam int FRAC_BITS  = 22;
    localparam int OFFSET_MV  = 10;
    localparam int VOLT_MAX   = 32767;

    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef logic [GAIN_W-1:0] gain_t;

    localparam gain_t GAIN_RESET [NUM_GAINS] = '{
        15'd9947, 15'd9947, 15'd9947, 15'd9947,
        15'd9947, 15'd4096, 15'd8192, 15'd8192
    };

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } hist_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } sort_ctrl_t;

endpackage

/* src/mavs_hist.sv */
// Sample history store: one row of WINDOW samples per channel, registered read.
// Per-row valid bits make unwritten rows read as zero. Depends on mavs_pkg.
module mavs_hist #(
    parameter int NUM_CHANNELS = mavs_pkg::NUM_CHANNELS_DEF,
    parameter int WINDOW       = mavs_pkg::WINDOW_DEF,
    localparam int CH_W        = $clog2(NUM_CHANNELS),
    localparam int ROW_W       = WINDOW * mavs_pkg::DATA_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mavs_pkg::hist_ctrl_t ctrl,
    input  logic [CH_W-1:0]      addr,
    input  logic [ROW_W-1:0]     wr_data,
    output logic [ROW_W-1:0]     rd_data
);

    logic [ROW_W-1:0]        hist_mem [NUM_CHANNELS];
    logic [ROW_W-1:0]        rd_data_reg;
    logic                    rd_valid_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            hist_mem[addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= hist_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* src/mavs_sorter.sv */
// Window sorter: one compare-swap unit on the two head taps, the rest rotating.
// WINDOW-1 passes of WINDOW-1 steps leave the window ascending. Depends on mavs_pkg.
module mavs_sorter #(
    parameter int WINDOW  = mavs_pkg::WINDOW_DEF,
    localparam int ROW_W  = WINDOW * mavs_pkg::DATA_W
) (
    input  logic                         clk,
    input  mavs_pkg::sort_ctrl_t         ctrl,
    input  logic [ROW_W-1:0]             load_row,
    output logic [mavs_pkg::DATA_W-1:0]  median
);

    logic [mavs_pkg::DATA_W-1:0] elem_reg [WINDOW];
    logic [mavs_pkg::DATA_W-1:0] lo;
    logic [mavs_pkg::DATA_W-1:0] hi;

    always_comb
    begin
        if (elem_reg[0] > elem_reg[1])
        begin
            lo = elem_reg[1];
            hi = elem_reg[0];
        end
        else
        begin
            lo = elem_reg[0];
            hi = elem_reg[1];
        end
    end

    // larger to the head, smaller to the tail; the last step puts both at the tail
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                elem_reg[i] <= load_row[i*mavs_pkg::DATA_W +: mavs_pkg::DATA_W];
            end
        end
        else if (ctrl.step)
        begin
            if (ctrl.last)
            begin
                for (int i = 0; i < WINDOW - 2; i++)
                begin
                    elem_reg[i] <= elem_reg[i+2];
                end
                elem_reg[WINDOW-2] <= lo;
                elem_reg[WINDOW-1] <= hi;
            end
            else
            begin
                elem_reg[0] <= hi;
                for (int i = 1; i < WINDOW - 1; i++)
                begin
                    elem_reg[i] <= elem_reg[i+1];
                end
                elem_reg[WINDOW-1] <= lo;
            end
        end
    end

    assign median = elem_reg[WINDOW/2];

endmodule

/* src/mavs_scale.sv */
// Shared multiplier with registered product, plus offset, rounding and saturation
// on the product register. Depends on mavs_pkg.
module mavs_scale (
    input  logic                          clk,
    input  logic                          en,
    input  logic [mavs_pkg::PART_W-1:0]   a,
    input  logic [mavs_pkg::GAIN_W-1:0]   b,
    output logic [mavs_pkg::PART_W-1:0]   part,
    output logic [mavs_pkg::VOLT_W-1:0]   volt
);

    localparam int PROD_W = mavs_pkg::PROD_W;
    localparam int Q_W    = PROD_W - mavs_pkg::FRAC_BITS;
    localparam logic [PROD_W-1:0] OFF_P  = PROD_W'(mavs_pkg::OFFSET_MV) << mavs_pkg::FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (mavs_pkg::FRAC_BITS - 1);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] rnd;
    logic [Q_W-1:0]    q;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign part = prod_reg[mavs_pkg::PART_W-1:0];
    assign rnd  = prod_reg - OFF_P + HALF_P;
    assign q    = rnd[PROD_W-1:mavs_pkg::FRAC_BITS];

    always_comb
    begin
        if (prod_reg <= OFF_P)
        begin
            volt = '0;
        end
        else if (q > Q_W'(mavs_pkg::VOLT_MAX))
        begin
            volt = mavs_pkg::VOLT_W'(mavs_pkg::VOLT_MAX);
        end
        else
        begin
            volt = q[mavs_pkg::VOLT_W-1:0];
        end
    end

endmodule

/* src/mux_adc_median_voltage_scaler_unit.sv */
// Each beat moves through S_READ, the sort passes in S_SORT, S_MUL1, S_MUL2 and S_FIN
// to the output register. No new beat is taken until the last one is through; the single
// compare-swap unit of the sorter sets the pace; a result waiting at the output stalls only the final step.
// Reset: channel counter to 0, history rows read as zero until written,
// gains to their defaults, output empty.
module mux_adc_median_voltage_scaler_unit #(
    parameter int NUM_CHANNELS = mavs_pkg::NUM_CHANNELS_DEF,
    parameter int WINDOW       = mavs_pkg::WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mavs_pkg::S_DATA_W-1:0]   s_tdata,   // raw_sample[9:0], ref_mv[22:10]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mavs_pkg::M_DATA_W-1:0]   m_tdata,   // channel[2:0], median_raw[12:3],
                                                       // voltage_mv[27:13]
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mavs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mavs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mavs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int ROW_W  = WINDOW * mavs_pkg::DATA_W;
    localparam int SW     = $clog2(WINDOW - 1);
    localparam int EXT_W  = CH_W + mavs_pkg::CHAN_W;
    localparam int DATA_W = mavs_pkg::DATA_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SORT = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [CH_W-1:0]              ch_reg;
    logic [CH_W-1:0]              ch_next;
    logic [SW-1:0]                step_reg;
    logic [SW-1:0]                step_next;
    logic [SW-1:0]                pass_reg;
    logic [SW-1:0]                pass_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [DATA_W-1:0]            sample_reg;
    logic [mavs_pkg::REF_W-1:0]   ref_reg;
    logic [mavs_pkg::CHAN_W-1:0]  out_ch_reg;
    logic [DATA_W-1:0]            out_med_reg;
    logic [mavs_pkg::VOLT_W-1:0]  out_volt_reg;
    mavs_pkg::gain_t              gain_reg [mavs_pkg::NUM_GAINS];

    logic                         accept;
    logic                         out_free;
    logic                         cfg_we;
    logic [mavs_pkg::GIDX_W-1:0]  cfg_idx;
    logic [EXT_W-1:0]             ch_ext;
    logic [mavs_pkg::CHAN_W-1:0]  ch_low;
    logic                         last_step;
    logic                         fin_ok;
    mavs_pkg::hist_ctrl_t         hist_ctrl;
    mavs_pkg::sort_ctrl_t         sort_ctrl;
    logic [ROW_W-1:0]             rd_row;
    logic [ROW_W-1:0]             new_row;
    logic [DATA_W-1:0]            median;
    logic                         mul_en;
    logic [mavs_pkg::PART_W-1:0]  mul_a;
    logic [mavs_pkg::GAIN_W-1:0]  mul_b;
    logic [mavs_pkg::PART_W-1:0]  part;
    logic [mavs_pkg::VOLT_W-1:0]  volt;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign fin_ok    = (state_reg == S_FIN) && out_free;
    assign last_step = (step_reg == SW'(WINDOW - 2));
    assign ch_ext    = EXT_W'(ch_reg);
    assign ch_low    = ch_ext[mavs_pkg::CHAN_W-1:0];

    assign hist_ctrl.rd_en = accept;
    assign hist_ctrl.wr_en = (state_reg == S_READ);
    assign new_row         = {sample_reg, rd_row[ROW_W-1:DATA_W]};

    assign sort_ctrl.load = (state_reg == S_READ);
    assign sort_ctrl.step = (state_reg == S_SORT);
    assign sort_ctrl.last = last_step;

    assign mul_en = (state_reg == S_MUL1) || (state_reg == S_MUL2);
    assign mul_a  = (state_reg == S_MUL1) ? mavs_pkg::PART_W'(median) : part;
    assign mul_b  = (state_reg == S_MUL1) ? mavs_pkg::GAIN_W'(ref_reg) : gain_reg[ch_low];

    mavs_hist #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .WINDOW       (WINDOW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hist_ctrl),
        .addr    (ch_reg),
        .wr_data (new_row),
        .rd_data (rd_row)
    );

    mavs_sorter #(
        .WINDOW (WINDOW)
    ) u_sorter (
        .clk      (clk),
        .ctrl     (sort_ctrl),
        .load_row (new_row),
        .median   (median)
    );

    mavs_scale u_scale (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .part (part),
        .volt (volt)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                step_next  = '0;
                pass_next  = '0;
                state_next = S_SORT;
            end
            S_SORT:
            begin
                if (last_step)
                begin
                    step_next = '0;
                    if (pass_reg == SW'(WINDOW - 2))
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        pass_next = pass_reg + SW'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ch_next = ch_reg;
        if (fin_ok)
        begin
            ch_next = (ch_reg == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch_reg + CH_W'(1);
        end
    end

    always_comb
    begin
        priority if (fin_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            step_reg      <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[DATA_W-1:0];
            ref_reg    <= s_tdata[DATA_W +: mavs_pkg::REF_W];
        end
        if (fin_ok)
        begin
            out_ch_reg   <= ch_low;
            out_med_reg  <= median;
            out_volt_reg <= volt;
        end
    end

    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[mavs_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mavs_pkg::NUM_GAINS; i++)
            begin
                gain_reg[i] <= mavs_pkg::GAIN_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            gain_reg[cfg_idx] <= pwdata[mavs_pkg::GAIN_W-1:0];
        end
    end

    assign prdata = mavs_pkg::APB_DATA_W'(gain_reg[cfg_idx]);
    assign pready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (mavs_pkg::M_DATA_W - mavs_pkg::CHAN_W - DATA_W - mavs_pkg::VOLT_W)'(0),
        out_volt_reg, out_med_reg, out_ch_reg
    };

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        fin_ok |=> (m_tvalid && state_reg == S_IDLE))
        else $error("finished item not presented at the output");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= CH_W'(NUM_CHANNELS - 1))
        else $error("channel counter out of range");

    a_sort_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT) |-> (pass_reg <= SW'(WINDOW - 2)))
        else $error("sort pass count overran");

endmodule
